// File: rtl/tmq_pkg.sv
package tmq_pkg;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_BUILD   = 3'd1,
    OP_DEFORM  = 3'd2,
    OP_RD_NODE = 3'd3,
    OP_RD_TILE = 3'd4
  } tmq_op_t;

  // grid shift after reset
  localparam logic [2:0] SHIFT_RESET = 3'd6;

  // deform walk phases, in the order the edits are applied
  typedef enum logic [3:0] {
    PH_INNER     = 4'd0,
    PH_TOP_ROW   = 4'd1,
    PH_TOP_LEFT  = 4'd2,
    PH_TOP_RIGHT = 4'd3,
    PH_BOT_ROW   = 4'd4,
    PH_BOT_LEFT  = 4'd5,
    PH_BOT_RIGHT = 4'd6,
    PH_LEFT_COL  = 4'd7,
    PH_RIGHT_COL = 4'd8,
    PH_DONE      = 4'd9
  } tmq_phase_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_RD_NODE,
    ST_RD_TILE,
    ST_B_LEAF_RD,
    ST_B_LEAF_WR,
    ST_B_CH_RD,
    ST_B_CH_ACC,
    ST_B_NODE_WR,
    ST_D_SEEK,
    ST_D_TILE,
    ST_D_MOD,
    ST_D_ANC,
    ST_D_ACMP,
    ST_DONE
  } tmq_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic c_rd_in;
    logic c_rd_walk;
    logic c_rd_build;
    logic c_wr_load;
    logic c_wr_dfm;
    logic leaf_wr;
    logic b_rd_node;
    logic b_rd_child;
    logic ch_acc;
    logic node_wr;
    logic b_rd_anc;
    logic b_wr_anc;
    logic cap_node;
    logic cap_tile;
    logic bld_init;
    logic walk_init;
    logic walk_skip;
    logic walk_start;
    logic walk_adv;
    logic res_load;
  } tmq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    tmq_op_t op;
    logic    tile_ok;
    logic    node_ok;
    logic    leaf_last;
    logic    cc_last;
    logic    node_zero;
    logic    ph_done;
    logic    ph_empty;
    logic    walk_ok;
    logic    walk_last;
    logic    j_zero;
    logic    covers;
    logic    out_free;
  } tmq_stat_t;

  // corner mask of each deform phase
  function automatic logic [3:0] phase_mask(tmq_phase_t ph);
    logic [3:0] m;
    case (ph)
      PH_INNER:     m = 4'd15;
      PH_TOP_ROW:   m = 4'd12;
      PH_TOP_LEFT:  m = 4'd8;
      PH_TOP_RIGHT: m = 4'd4;
      PH_BOT_ROW:   m = 4'd3;
      PH_BOT_LEFT:  m = 4'd2;
      PH_BOT_RIGHT: m = 4'd1;
      PH_LEFT_COL:  m = 4'd10;
      PH_RIGHT_COL: m = 4'd5;
      default:      m = 4'd0;
    endcase
    return m;
  endfunction

  // min in low byte, max in high byte, over the four corners
  function automatic logic [15:0] corner_bounds(logic [31:0] w);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] h;
    lo = 8'hFF;
    hi = 8'h00;
    for (int k = 0; k < 4; k++) begin
      h = w[8*k +: 8];
      if (h < lo) lo = h;
      if (h > hi) hi = h;
    end
    return {hi, lo};
  endfunction

endpackage

// File: rtl/tmq_in_if.sv
interface tmq_in_if #(parameter int MAX_SHIFT = 6);
  localparam int TILES = 1 << (2 * MAX_SHIFT);
  localparam int NODES = TILES + (TILES - 1) / 3;
  localparam int NW    = $clog2(NODES);

  logic                  valid;
  logic                  ready;
  logic [2:0]            operation;
  logic [MAX_SHIFT-1:0]  tile_x;
  logic [MAX_SHIFT-1:0]  tile_y;
  logic [MAX_SHIFT:0]    tile_x_end;
  logic [MAX_SHIFT:0]    tile_y_end;
  logic signed [7:0]     change;
  logic [7:0]            corner_a;
  logic [7:0]            corner_b;
  logic [7:0]            corner_c;
  logic [7:0]            corner_d;
  logic [NW-1:0]         node_index;

  modport source (
    output valid, operation, tile_x, tile_y, tile_x_end, tile_y_end, change,
           corner_a, corner_b, corner_c, corner_d, node_index,
    input  ready
  );
  modport sink (
    input  valid, operation, tile_x, tile_y, tile_x_end, tile_y_end, change,
           corner_a, corner_b, corner_c, corner_d, node_index,
    output ready
  );
endinterface

// File: rtl/tmq_out_if.sv
interface tmq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] low_bound;
  logic [7:0] high_bound;
  logic [7:0] out_corner_a;
  logic [7:0] out_corner_b;
  logic [7:0] out_corner_c;
  logic [7:0] out_corner_d;

  modport source (
    output valid, low_bound, high_bound, out_corner_a, out_corner_b,
           out_corner_c, out_corner_d,
    input  ready
  );
  modport sink (
    input  valid, low_bound, high_bound, out_corner_a, out_corner_b,
           out_corner_c, out_corner_d,
    output ready
  );
endinterface

// File: rtl/tmq_ram.sv
module tmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/tmq_ctrl.sv
module tmq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmq_pkg::tmq_stat_t  st,
  output tmq_pkg::tmq_cmd_t   cmd
);
  tmq_pkg::tmq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tmq_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tmq_pkg::ST_DISP;
      end
      tmq_pkg::ST_DISP: begin
        case (st.op)
          tmq_pkg::OP_BUILD:   state_nxt = tmq_pkg::ST_B_LEAF_RD;
          tmq_pkg::OP_DEFORM:  state_nxt = tmq_pkg::ST_D_SEEK;
          tmq_pkg::OP_RD_NODE: state_nxt = st.node_ok ? tmq_pkg::ST_RD_NODE
                                                      : tmq_pkg::ST_DONE;
          tmq_pkg::OP_RD_TILE: state_nxt = st.tile_ok ? tmq_pkg::ST_RD_TILE
                                                      : tmq_pkg::ST_DONE;
          default:             state_nxt = tmq_pkg::ST_DONE;
        endcase
      end
      tmq_pkg::ST_RD_NODE:   state_nxt = tmq_pkg::ST_DONE;
      tmq_pkg::ST_RD_TILE:   state_nxt = tmq_pkg::ST_DONE;
      tmq_pkg::ST_B_LEAF_RD: state_nxt = tmq_pkg::ST_B_LEAF_WR;
      tmq_pkg::ST_B_LEAF_WR: begin
        state_nxt = st.leaf_last ? tmq_pkg::ST_B_CH_RD : tmq_pkg::ST_B_LEAF_RD;
      end
      tmq_pkg::ST_B_CH_RD:   state_nxt = tmq_pkg::ST_B_CH_ACC;
      tmq_pkg::ST_B_CH_ACC: begin
        state_nxt = st.cc_last ? tmq_pkg::ST_B_NODE_WR : tmq_pkg::ST_B_CH_RD;
      end
      tmq_pkg::ST_B_NODE_WR: begin
        state_nxt = st.node_zero ? tmq_pkg::ST_DONE : tmq_pkg::ST_B_CH_RD;
      end
      tmq_pkg::ST_D_SEEK: begin
        if (st.ph_done)       state_nxt = tmq_pkg::ST_DONE;
        else if (!st.ph_empty) state_nxt = tmq_pkg::ST_D_TILE;
      end
      tmq_pkg::ST_D_TILE: begin
        if (st.walk_ok)        state_nxt = tmq_pkg::ST_D_MOD;
        else if (st.walk_last) state_nxt = tmq_pkg::ST_D_SEEK;
      end
      tmq_pkg::ST_D_MOD: state_nxt = tmq_pkg::ST_D_ANC;
      tmq_pkg::ST_D_ANC: begin
        if (!st.j_zero)        state_nxt = tmq_pkg::ST_D_ACMP;
        else if (st.walk_last) state_nxt = tmq_pkg::ST_D_SEEK;
        else                   state_nxt = tmq_pkg::ST_D_TILE;
      end
      tmq_pkg::ST_D_ACMP: begin
        if (!st.covers)        state_nxt = tmq_pkg::ST_D_ANC;
        else if (st.walk_last) state_nxt = tmq_pkg::ST_D_SEEK;
        else                   state_nxt = tmq_pkg::ST_D_TILE;
      end
      tmq_pkg::ST_DONE: begin
        if (st.out_free) state_nxt = tmq_pkg::ST_IDLE;
      end
      default: state_nxt = tmq_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      tmq_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      tmq_pkg::ST_DISP: begin
        case (st.op)
          tmq_pkg::OP_LOAD:    cmd.c_wr_load = st.tile_ok;
          tmq_pkg::OP_BUILD:   cmd.bld_init  = 1'b1;
          tmq_pkg::OP_DEFORM:  cmd.walk_init = 1'b1;
          tmq_pkg::OP_RD_NODE: cmd.b_rd_node = st.node_ok;
          tmq_pkg::OP_RD_TILE: cmd.c_rd_in   = st.tile_ok;
          default: ;
        endcase
      end
      tmq_pkg::ST_RD_NODE:   cmd.cap_node   = 1'b1;
      tmq_pkg::ST_RD_TILE:   cmd.cap_tile   = 1'b1;
      tmq_pkg::ST_B_LEAF_RD: cmd.c_rd_build = 1'b1;
      tmq_pkg::ST_B_LEAF_WR: cmd.leaf_wr    = 1'b1;
      tmq_pkg::ST_B_CH_RD:   cmd.b_rd_child = 1'b1;
      tmq_pkg::ST_B_CH_ACC:  cmd.ch_acc     = 1'b1;
      tmq_pkg::ST_B_NODE_WR: cmd.node_wr    = 1'b1;
      tmq_pkg::ST_D_SEEK: begin
        if (!st.ph_done) begin
          cmd.walk_skip  = st.ph_empty;
          cmd.walk_start = !st.ph_empty;
        end
      end
      tmq_pkg::ST_D_TILE: begin
        cmd.c_rd_walk = st.walk_ok;
        cmd.walk_adv  = !st.walk_ok;
      end
      tmq_pkg::ST_D_MOD: cmd.c_wr_dfm = 1'b1;
      tmq_pkg::ST_D_ANC: begin
        cmd.b_rd_anc = !st.j_zero;
        cmd.walk_adv = st.j_zero;
      end
      tmq_pkg::ST_D_ACMP: begin
        cmd.b_wr_anc = !st.covers;
        cmd.walk_adv = st.covers;
      end
      tmq_pkg::ST_DONE: cmd.res_load = st.out_free;
      default: ;
    endcase
  end
endmodule

// File: rtl/tmq_dp.sv
module tmq_dp #(
  parameter int MAX_SHIFT = 6
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [2:0]                               cfg_wr_data,
  input  logic [2:0]                               in_operation,
  input  logic [MAX_SHIFT-1:0]                     in_tile_x,
  input  logic [MAX_SHIFT-1:0]                     in_tile_y,
  input  logic [MAX_SHIFT:0]                       in_tile_x_end,
  input  logic [MAX_SHIFT:0]                       in_tile_y_end,
  input  logic [7:0]                               in_change,
  input  logic [31:0]                              in_corners,
  input  logic [$clog2((1 << (2 * MAX_SHIFT))
                 + ((1 << (2 * MAX_SHIFT)) - 1) / 3)-1:0] in_node_index,
  input  tmq_pkg::tmq_cmd_t                        cmd,
  output tmq_pkg::tmq_stat_t                       st,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic [15:0]                              out_bounds,
  output logic [31:0]                              out_corners
);
  localparam int TW    = 2 * MAX_SHIFT;
  localparam int TILES = 1 << TW;
  localparam int NODES = TILES + (TILES - 1) / 3;
  localparam int NW    = $clog2(NODES);
  localparam int CW    = MAX_SHIFT + 2;
  localparam int SW    = $clog2(MAX_SHIFT + 1);

  function automatic logic [TW-1:0] morton(logic [MAX_SHIFT-1:0] x,
                                           logic [MAX_SHIFT-1:0] y);
    logic [TW-1:0] i;
    for (int b = 0; b < MAX_SHIFT; b++) begin
      i[2*b]   = x[b];
      i[2*b+1] = y[b];
    end
    return i;
  endfunction

  // configuration and latched item
  logic [2:0]     shift_r;
  logic [2:0]     op_r;
  logic [CW-1:0]  x0_r, y0_r, x1_r, y1_r;
  logic [7:0]     delta_r;
  logic [31:0]    load_r;
  logic [NW-1:0]  node_r;

  // walker, build and ancestor state
  tmq_pkg::tmq_phase_t ph_r;
  logic [CW-1:0]  wx_r, wy_r;
  logic [NW-1:0]  idx_r;
  logic [1:0]     cc_r;
  logic [7:0]     acc_lo_r, acc_hi_r;
  logic [NW-1:0]  j_r;
  logic [7:0]     lo_r, hi_r;

  // results
  logic [15:0]    res_b_r;
  logic [31:0]    res_c_r;
  logic           out_valid_r;
  logic [15:0]    out_b_r;
  logic [31:0]    out_c_r;

  // memories
  logic           c_we, b_we;
  logic [TW-1:0]  c_waddr, c_raddr;
  logic [31:0]    c_wdata, c_rdata;
  logic [NW-1:0]  b_waddr, b_raddr;
  logic [15:0]    b_wdata, b_rdata;

  tmq_ram #(.WIDTH(32), .DEPTH(TILES)) u_corner_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  tmq_ram #(.WIDTH(16), .DEPTH(NODES)) u_bound_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // map geometry from the grid shift
  logic [SW-1:0]  s_eff;
  logic [CW-1:0]  side;
  logic [NW-1:0]  tiles, base, total;

  always_comb begin
    if (shift_r == 3'd0)                 s_eff = SW'(1);
    else if (32'(shift_r) > MAX_SHIFT)   s_eff = SW'(MAX_SHIFT);
    else                                 s_eff = SW'(shift_r);
    side  = CW'(1) << s_eff;
    tiles = NW'(1) << {s_eff, 1'b0};
    for (int b = 0; b < NW; b++) begin
      base[b] = (b % 2 == 0) && (b < 2 * 32'(s_eff));
    end
    total = tiles + base;
  end

  // deform phase ranges
  logic [CW-1:0] xs, xe, ys, ye;
  logic          ph_en;
  logic          x0nz, y0nz, x1ns, y1ns;

  always_comb begin
    x0nz = x0_r != '0;
    y0nz = y0_r != '0;
    x1ns = x1_r != side;
    y1ns = y1_r != side;
    xs = x0_r;  xe = x1_r;
    ys = y0_r;  ye = y1_r;
    ph_en = 1'b1;
    case (ph_r)
      tmq_pkg::PH_INNER: ;
      tmq_pkg::PH_TOP_ROW: begin
        ys = y0_r - CW'(1);  ye = y0_r;  ph_en = y0nz;
      end
      tmq_pkg::PH_TOP_LEFT: begin
        xs = x0_r - CW'(1);  xe = x0_r;
        ys = y0_r - CW'(1);  ye = y0_r;  ph_en = y0nz && x0nz;
      end
      tmq_pkg::PH_TOP_RIGHT: begin
        xs = x1_r;  xe = x1_r + CW'(1);
        ys = y0_r - CW'(1);  ye = y0_r;  ph_en = y0nz && x1ns;
      end
      tmq_pkg::PH_BOT_ROW: begin
        ys = y1_r;  ye = y1_r + CW'(1);  ph_en = y1ns;
      end
      tmq_pkg::PH_BOT_LEFT: begin
        xs = x0_r - CW'(1);  xe = x0_r;
        ys = y1_r;  ye = y1_r + CW'(1);  ph_en = y1ns && x0nz;
      end
      tmq_pkg::PH_BOT_RIGHT: begin
        xs = x1_r;  xe = x1_r + CW'(1);
        ys = y1_r;  ye = y1_r + CW'(1);  ph_en = y1ns && x1ns;
      end
      tmq_pkg::PH_LEFT_COL: begin
        xs = x0_r - CW'(1);  xe = x0_r;  ph_en = x0nz;
      end
      tmq_pkg::PH_RIGHT_COL: begin
        xs = x1_r;  xe = x1_r + CW'(1);  ph_en = x1ns;
      end
      default: ph_en = 1'b0;
    endcase
  end

  // addresses and write data
  logic [TW-1:0]  in_tile, walk_tile;
  logic [NW-1:0]  leaf_j, child, anc;
  logic [31:0]    new_word;
  logic [15:0]    new_b;
  logic [3:0]     mask;
  logic [7:0]     wid_lo, wid_hi;

  always_comb begin
    in_tile   = morton(x0_r[MAX_SHIFT-1:0], y0_r[MAX_SHIFT-1:0]);
    walk_tile = morton(wx_r[MAX_SHIFT-1:0], wy_r[MAX_SHIFT-1:0]);
    leaf_j    = base + NW'(walk_tile);
    child     = (idx_r << 2) + NW'(cc_r) + NW'(1);
    anc       = (j_r - NW'(1)) >> 2;
    mask      = tmq_pkg::phase_mask(ph_r);
    for (int k = 0; k < 4; k++) begin
      new_word[8*k +: 8] = mask[k] ? c_rdata[8*k +: 8] + delta_r : c_rdata[8*k +: 8];
    end
    new_b  = tmq_pkg::corner_bounds(new_word);
    wid_lo = (b_rdata[7:0] > lo_r) ? lo_r : b_rdata[7:0];
    wid_hi = (b_rdata[15:8] < hi_r) ? hi_r : b_rdata[15:8];

    c_we    = cmd.c_wr_load || cmd.c_wr_dfm;
    c_waddr = cmd.c_wr_load ? in_tile : walk_tile;
    c_wdata = cmd.c_wr_load ? load_r : new_word;
    if (cmd.c_rd_in)        c_raddr = in_tile;
    else if (cmd.c_rd_walk) c_raddr = walk_tile;
    else                    c_raddr = idx_r[TW-1:0];

    b_we = cmd.leaf_wr || cmd.c_wr_dfm || cmd.node_wr || cmd.b_wr_anc;
    if (cmd.leaf_wr) begin
      b_waddr = base + idx_r;
      b_wdata = tmq_pkg::corner_bounds(c_rdata);
    end else if (cmd.c_wr_dfm) begin
      b_waddr = leaf_j;
      b_wdata = new_b;
    end else if (cmd.node_wr) begin
      b_waddr = idx_r;
      b_wdata = {acc_hi_r, acc_lo_r};
    end else begin
      b_waddr = j_r;
      b_wdata = {wid_hi, wid_lo};
    end
    if (cmd.b_rd_node)       b_raddr = node_r;
    else if (cmd.b_rd_child) b_raddr = child;
    else                     b_raddr = anc;
  end

  // configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= tmq_pkg::SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) shift_r <= cfg_wr_data;
      if (cmd.res_load)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // item latch, results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_operation;
      x0_r    <= CW'(in_tile_x);
      y0_r    <= CW'(in_tile_y);
      x1_r    <= CW'(in_tile_x_end);
      y1_r    <= CW'(in_tile_y_end);
      delta_r <= in_change;
      load_r  <= in_corners;
      node_r  <= in_node_index;
      res_b_r <= '0;
      res_c_r <= '0;
    end
    if (cmd.cap_node) res_b_r <= b_rdata;
    if (cmd.cap_tile) res_c_r <= c_rdata;
    if (cmd.res_load) begin
      out_b_r <= res_b_r;
      out_c_r <= res_c_r;
    end
  end

  // build sweep: leaves, then inner nodes from the last down to the root
  always_ff @(posedge clk) begin
    if (cmd.bld_init) idx_r <= '0;
    if (cmd.leaf_wr || cmd.node_wr) begin
      acc_lo_r <= 8'hFF;
      acc_hi_r <= 8'h00;
      cc_r     <= '0;
    end
    if (cmd.leaf_wr) idx_r <= st.leaf_last ? base - NW'(1) : idx_r + NW'(1);
    if (cmd.node_wr) idx_r <= idx_r - NW'(1);
    if (cmd.ch_acc) begin
      if (b_rdata[7:0] < acc_lo_r)  acc_lo_r <= b_rdata[7:0];
      if (b_rdata[15:8] > acc_hi_r) acc_hi_r <= b_rdata[15:8];
      cc_r <= cc_r + 2'd1;
    end
  end

  // deform walker and ancestor chain
  always_ff @(posedge clk) begin
    if (cmd.walk_init) ph_r <= tmq_pkg::PH_INNER;
    if (cmd.walk_skip) ph_r <= tmq_pkg::tmq_phase_t'(ph_r + 4'd1);
    if (cmd.walk_start) begin
      wx_r <= xs;
      wy_r <= ys;
    end
    if (cmd.walk_adv) begin
      if (st.walk_last) begin
        ph_r <= tmq_pkg::tmq_phase_t'(ph_r + 4'd1);
      end else if (wx_r + CW'(1) >= xe) begin
        wx_r <= xs;
        wy_r <= wy_r + CW'(1);
      end else begin
        wx_r <= wx_r + CW'(1);
      end
    end
    if (cmd.c_wr_dfm) begin
      j_r  <= leaf_j;
      lo_r <= new_b[7:0];
      hi_r <= new_b[15:8];
    end
    if (cmd.b_rd_anc) j_r <= anc;
  end

  // status
  always_comb begin
    st.op        = tmq_pkg::tmq_op_t'(op_r);
    st.tile_ok   = (x0_r < side) && (y0_r < side);
    st.node_ok   = node_r < total;
    st.leaf_last = idx_r == tiles - NW'(1);
    st.cc_last   = cc_r == 2'd3;
    st.node_zero = idx_r == '0;
    st.ph_done   = ph_r == tmq_pkg::PH_DONE;
    st.ph_empty  = !ph_en || (xs >= xe) || (ys >= ye);
    st.walk_ok   = (wx_r < side) && (wy_r < side);
    st.walk_last = (wx_r + CW'(1) >= xe) && (wy_r + CW'(1) >= ye);
    st.j_zero    = j_r == '0;
    st.covers    = (b_rdata[15:8] >= hi_r) && (b_rdata[7:0] <= lo_r);
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_bounds  = out_b_r;
  assign out_corners = out_c_r;
endmodule

// File: rtl/terrain_minmax_quadtree_top.sv
// Min/max quadtree over a square heightmap of tiles, one item at a time. The tile
// corners and the node bounds each sit in a RAM with one write and one registered
// read port, and those single ports set the timing: a load is one write, a tile or
// node read one read, a build a read and a write per leaf and four child reads and
// a write per inner node, and a deform a read and a write per tile of the rectangle
// and its border, a read per ancestor checked and a write per one that widens, and
// a skip per empty border phase. A finished result waits in an output register, so
// the next item is taken while it is still unclaimed. Node bounds are meaningful
// only after a build; grid_shift must be written only while the block is idle, which the block does not enforce.
module terrain_minmax_quadtree_top #(
  parameter int MAX_SHIFT = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  tmq_in_if.sink     in_item,
  tmq_out_if.source  out_item
);
  tmq_pkg::tmq_cmd_t  cmd;
  tmq_pkg::tmq_stat_t st;
  logic [15:0]        out_bounds;
  logic [31:0]        out_corners;

  tmq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_item.valid), .in_ready(in_item.ready),
    .st(st), .cmd(cmd)
  );

  tmq_dp #(.MAX_SHIFT(MAX_SHIFT)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_operation(in_item.operation),
    .in_tile_x(in_item.tile_x), .in_tile_y(in_item.tile_y),
    .in_tile_x_end(in_item.tile_x_end), .in_tile_y_end(in_item.tile_y_end),
    .in_change(in_item.change),
    .in_corners({in_item.corner_d, in_item.corner_c, in_item.corner_b,
                 in_item.corner_a}),
    .in_node_index(in_item.node_index),
    .cmd(cmd), .st(st),
    .out_ready(out_item.ready), .out_valid(out_item.valid),
    .out_bounds(out_bounds), .out_corners(out_corners)
  );

  assign out_item.low_bound    = out_bounds[7:0];
  assign out_item.high_bound   = out_bounds[15:8];
  assign out_item.out_corner_a = out_corners[7:0];
  assign out_item.out_corner_b = out_corners[15:8];
  assign out_item.out_corner_c = out_corners[23:16];
  assign out_item.out_corner_d = out_corners[31:24];

  // a result only moves into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_item.valid || out_item.ready))
    else $error("result loaded over an unclaimed result");

  // a new item is never taken while a result is being finished
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |-> !cmd.res_load)
    else $error("item accepted while finishing another");

  // a load only writes a tile inside the map
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.c_wr_load |-> st.tile_ok)
    else $error("load written outside the map");

  // an accepted item always leads to a dispatch on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("ready still high after accepting an item");
endmodule
